>>> hw/rtl/mks_pkg.sv
// Shared types and constants for the matrix keypad scanner.
// No dependencies; imported by mks_ctrl, mks_dp and matrix_keypad_scanner.
`default_nettype none

package mks_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned LinesW    = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CodeW     = 8;
  localparam int unsigned MsW       = 16;
  localparam int unsigned KeymapLen = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRowCount    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgColumnCount = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDebounceMs  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHoldMs      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgKeymapLow   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgKeymapHigh  = 3'd5;

  // reset values of the configuration registers
  localparam logic [2:0]     RowCountRst    = 3'd4;
  localparam logic [2:0]     ColumnCountRst = 3'd4;
  localparam logic [MsW-1:0] DebounceMsRst  = 16'd50;
  localparam logic [MsW-1:0] HoldMsRst      = 16'd1000;

  typedef enum logic [1:0] {
    PadIdle     = 2'd0,
    PadPressed  = 2'd1,
    PadHold     = 2'd2,
    PadReleased = 2'd3
  } pad_state_e;

  typedef struct packed {
    logic start;   // capture the poll and rewind the scan
    logic step;    // visit one matrix position
    logic finish;  // resolve the new key and load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_end;  // the current position is the last one of this scan
    logic out_free;  // the result register can take a new result
  } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/mks_ctrl.sv
// Sequencer for one poll: accept, scan positions, deliver the result.
// Depends on mks_pkg for the command and status structs.
`default_nettype none

module mks_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire mks_pkg::dp_status_t status_i,
  output mks_pkg::ctrl_cmd_t   cmd_o
);
  import mks_pkg::*;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StScan   = 3'b010,
    StFinish = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        cmd_o.step = 1'b1;
        if (status_i.scan_end) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        // hold until the previous result has been taken
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mks_dp.sv
// Datapath: configuration, key tracking state, scan counters, result register.
// Depends on mks_pkg; driven by mks_ctrl through command and status structs.
`default_nettype none

module mks_dp #(
  parameter int unsigned MAX_ROWS    = 4,
  parameter int unsigned MAX_COLUMNS = 4
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [mks_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire  [mks_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  wire  [mks_pkg::LinesW-1:0]        key_lines_i,
  input  wire  [mks_pkg::TimeW-1:0]         time_ms_i,
  input  wire                               out_ready_i,
  output logic                              out_valid_o,
  output logic [mks_pkg::CodeW-1:0]         new_key_o,
  output logic [1:0]                        key_state_o,
  output logic [mks_pkg::CodeW-1:0]         held_key_o,
  input  wire mks_pkg::ctrl_cmd_t           cmd_i,
  output mks_pkg::dp_status_t               status_o
);
  import mks_pkg::*;

  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam logic [3:0]  MaxRows4 = 4'(MAX_ROWS);
  localparam logic [3:0]  MaxCols4 = 4'(MAX_COLUMNS);

  // configuration
  logic [2:0]          rows_q, cols_q;
  logic [MsW-1:0]      debounce_q, hold_q;
  logic [CfgDataW-1:0] keymap_lo_q, keymap_hi_q;

  // poll payload
  logic [LinesW-1:0] lines_q;
  logic [TimeW-1:0]  now_q;

  // scan position and tracking state
  logic [RowW-1:0]   row_q, row_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [5:0]        idx_q, idx_d;
  logic [CodeW-1:0]  found_q, found_d;
  logic [CodeW-1:0]  cur_q, cur_d;
  pad_state_e        pad_q, pad_d;
  logic [TimeW-1:0]  last_q, last_d;

  // result register
  logic              out_valid_q;
  logic [CodeW-1:0]  new_key_q, held_key_q;
  pad_state_e        key_state_q;

  logic [3:0]           rows_eff, cols_eff, row4, col4;
  logic                 empty, last_row, last_col;
  logic [2*CfgDataW-1:0] keymap;
  logic [CodeW-1:0]     code;
  logic                 closed, match, deb_ok, hold_ok, stop_hit, report;
  logic [TimeW-1:0]     elapsed;

  assign rows_eff = (4'(rows_q) > MaxRows4) ? MaxRows4 : 4'(rows_q);
  assign cols_eff = (4'(cols_q) > MaxCols4) ? MaxCols4 : 4'(cols_q);
  assign empty    = (rows_eff == 4'd0) || (cols_eff == 4'd0);
  assign row4     = 4'(row_q);
  assign col4     = 4'(col_q);
  assign last_row = (row4 + 4'd1) >= rows_eff;
  assign last_col = (col4 + 4'd1) >= cols_eff;

  assign keymap = {keymap_hi_q, keymap_lo_q};
  assign code   = (idx_q < 6'(KeymapLen)) ? keymap[{idx_q[3:0], 3'b000} +: CodeW] : '0;
  // switches outside the 4x4 line set read as open
  assign closed = (row4 < 4'd4) && (col4 < 4'd4) && lines_q[{row4[1:0], col4[1:0]}];

  assign elapsed  = now_q - last_q;
  assign deb_ok   = elapsed >= TimeW'(debounce_q);
  assign hold_ok  = elapsed >= TimeW'(hold_q);
  assign match    = (code == cur_q);
  assign stop_hit = !match && deb_ok && closed;
  assign report   = (found_q != '0) && (found_q != cur_q);

  assign status_o.scan_end = empty || stop_hit || (last_row && last_col);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    idx_d   = idx_q;
    found_d = found_q;
    cur_d   = cur_q;
    pad_d   = pad_q;
    last_d  = last_q;
    if (cmd_i.start) begin
      row_d   = '0;
      col_d   = '0;
      idx_d   = '0;
      found_d = '0;
    end else if (cmd_i.step && !empty) begin
      if (match) begin
        if (hold_ok && closed) begin
          pad_d = PadHold;
        end
        if (deb_ok && !closed) begin
          pad_d = PadReleased;
          cur_d = '0;
        end
      end else if (stop_hit) begin
        found_d = code;
        last_d  = now_q;
      end
      // advance down the column, then to the top of the next column
      if (!last_row) begin
        row_d = RowW'(row4 + 4'd1);
        idx_d = idx_q + 6'(cols_eff);
      end else begin
        row_d = '0;
        col_d = ColW'(col4 + 4'd1);
        idx_d = 6'(col4) + 6'd1;
      end
    end else if (cmd_i.finish && report) begin
      cur_d = found_q;
      pad_d = PadPressed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= RowCountRst;
      cols_q      <= ColumnCountRst;
      debounce_q  <= DebounceMsRst;
      hold_q      <= HoldMsRst;
      keymap_lo_q <= '0;
      keymap_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRowCount:    rows_q      <= cfg_wdata_i[2:0];
        CfgColumnCount: cols_q      <= cfg_wdata_i[2:0];
        CfgDebounceMs:  debounce_q  <= cfg_wdata_i[MsW-1:0];
        CfgHoldMs:      hold_q      <= cfg_wdata_i[MsW-1:0];
        CfgKeymapLow:   keymap_lo_q <= cfg_wdata_i;
        CfgKeymapHigh:  keymap_hi_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      idx_q   <= '0;
      found_q <= '0;
      cur_q   <= '0;
      pad_q   <= PadIdle;
      last_q  <= '0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      cur_q   <= cur_d;
      pad_q   <= pad_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      lines_q <= key_lines_i;
      now_q   <= time_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      new_key_q   <= report ? found_q : '0;
      key_state_q <= report ? PadPressed : pad_q;
      held_key_q  <= report ? found_q : cur_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_key_o   = new_key_q;
  assign key_state_o = key_state_q;
  assign held_key_o  = held_key_q;

  a_finish_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("result register not loaded after finish");

  a_release_clears_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && key_state_q == PadReleased) |-> (held_key_q == '0))
    else $error("released state reported with a tracked key");

  a_new_key_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && new_key_q != '0) |-> (held_key_q == new_key_q && key_state_q == PadPressed))
    else $error("reported key is not the tracked pressed key");

endmodule

`default_nettype wire

>>> hw/rtl/matrix_keypad_scanner.sv
// Top level of the matrix keypad scanner: sequencer plus datapath.
// Depends on mks_pkg, mks_ctrl and mks_dp.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   poll     | in_valid_i/in_ready_o, key_lines_i, time_ms_i | in
//   result   | out_valid_o/out_ready_i, new_key_o,       | out
//            | key_state_o, held_key_o                   |
//   config   | cfg_we_i, cfg_idx_i, cfg_wdata_i          | in
//
// A poll is accepted, scanned and finished; the scan visits N positions (1 to
// rows*columns, 1 when rows or columns is zero), one matrix position per cycle,
// and stops early on a debounced new press.
// The next poll is accepted once the result sits in the output register.
// A stalled result holds the block in its finish step until it is taken.
// Reset restores the register defaults and clears the tracked key.
`default_nettype none

module matrix_keypad_scanner #(
  parameter int unsigned MAX_ROWS    = 4,
  parameter int unsigned MAX_COLUMNS = 4
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [mks_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [mks_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  [mks_pkg::LinesW-1:0]    key_lines_i,
  input  wire  [mks_pkg::TimeW-1:0]     time_ms_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [mks_pkg::CodeW-1:0]     new_key_o,
  output logic [1:0]                    key_state_o,
  output logic [mks_pkg::CodeW-1:0]     held_key_o
);
  import mks_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mks_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_lines_i (key_lines_i),
    .time_ms_i   (time_ms_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .new_key_o   (new_key_o),
    .key_state_o (key_state_o),
    .held_key_o  (held_key_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire

>>> test/mks_tracker_pkg.sv
// Scoreboard for the matrix keypad scanner: a poll-by-poll predictor of the
// tracked key and pad state, and the queue of results it still expects.
// Depends on mks_pkg for register indexes, widths and the pad state codes.
package mks_tracker_pkg;

  import mks_pkg::*;

  localparam int unsigned MaxRows    = 4;
  localparam int unsigned MaxColumns = 4;

  typedef struct packed {
    logic [CodeW-1:0] new_key;
    pad_state_e       key_state;
    logic [CodeW-1:0] held_key;
  } key_report_t;

  class keypad_tracker;
    logic [2:0]                 row_count;
    logic [2:0]                 column_count;
    logic [MsW-1:0]             debounce_ms;
    logic [MsW-1:0]             hold_ms;
    logic [2*CfgDataW-1:0]      keymap;
    logic [CodeW-1:0]           tracked_key;
    pad_state_e                 pad_state;
    logic [TimeW-1:0]           last_change_ms;
    key_report_t                pending_reports[$];
    int unsigned                failures;

    function new();
      row_count      = RowCountRst;
      column_count   = ColumnCountRst;
      debounce_ms    = DebounceMsRst;
      hold_ms        = HoldMsRst;
      keymap         = '0;
      tracked_key    = '0;
      pad_state      = PadIdle;
      last_change_ms = '0;
      failures       = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CfgRowCount:    row_count = value[2:0];
        CfgColumnCount: column_count = value[2:0];
        CfgDebounceMs:  debounce_ms = value[MsW-1:0];
        CfgHoldMs:      hold_ms = value[MsW-1:0];
        CfgKeymapLow:   keymap[CfgDataW-1:0] = value;
        CfgKeymapHigh:  keymap[2*CfgDataW-1:CfgDataW] = value;
        default: ;
      endcase
    endfunction

    // Scan column by column, row by row, and queue the result of the poll.
    function void note_poll(logic [LinesW-1:0] lines, logic [TimeW-1:0] now);
      int unsigned      rows;
      int unsigned      cols;
      int unsigned      idx;
      logic [CodeW-1:0] code;
      logic [CodeW-1:0] found;
      logic [CodeW-1:0] reported;
      logic             closed;
      logic             stop;
      logic [TimeW-1:0] elapsed;
      rows     = (row_count > MaxRows) ? MaxRows : row_count;
      cols     = (column_count > MaxColumns) ? MaxColumns : column_count;
      found    = '0;
      reported = '0;
      stop     = 1'b0;
      for (int c = 0; c < cols && !stop; c++) begin
        for (int r = 0; r < rows && !stop; r++) begin
          idx     = c + r * cols;
          code    = (idx < KeymapLen) ? keymap[idx*8 +: 8] : '0;
          closed  = (r < 4 && c < 4) ? lines[r*4 + c] : 1'b0;
          elapsed = now - last_change_ms;
          if (code == tracked_key) begin
            if (elapsed >= hold_ms && closed) pad_state = PadHold;
            if (elapsed >= debounce_ms && !closed) begin
              // clear at once: later positions compare against no key
              pad_state   = PadReleased;
              tracked_key = '0;
            end
          end else if (elapsed >= debounce_ms && closed) begin
            found          = code;
            last_change_ms = now;
            stop           = 1'b1;
          end
        end
      end
      if (found != '0 && found != tracked_key) begin
        tracked_key = found;
        pad_state   = PadPressed;
        reported    = found;
      end
      pending_reports.push_back('{reported, pad_state, tracked_key});
    endfunction

    function void check_report(logic [CodeW-1:0] new_key, logic [1:0] key_state,
                               logic [CodeW-1:0] held_key);
      key_report_t want;
      if (pending_reports.size() == 0) begin
        $error("result transfer with none pending: new_key %0d key_state %0d held_key %0d",
               new_key, key_state, held_key);
        failures++;
        return;
      end
      want = pending_reports.pop_front();
      if (new_key !== want.new_key) begin
        $error("new_key: expected %0d, actual %0d", want.new_key, new_key);
        failures++;
      end
      if (key_state !== want.key_state) begin
        $error("key_state: expected %0d, actual %0d", want.key_state, key_state);
        failures++;
      end
      if (held_key !== want.held_key) begin
        $error("held_key: expected %0d, actual %0d", want.held_key, held_key);
        failures++;
      end
    endfunction
  endclass

endpackage

>>> test/matrix_keypad_scanner_test.sv
// Testbench top for matrix_keypad_scanner: drives polls and register writes,
// stalls both channels at random and checks every result transfer.
// Depends on mks_pkg, mks_tracker_pkg and the scanner RTL.
module matrix_keypad_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mks_pkg::*;
  import mks_tracker_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgReserved0 = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgReserved1 = 3'd7;
  localparam int unsigned SettleCycles = 24;

  // {key lines, time}: single press, hold, release, code-zero key, wrap
  localparam logic [47:0] DirectedPolls [14] = '{
    {16'h0000, 32'd100},        {16'h0200, 32'd200},
    {16'h0200, 32'd210},        {16'h0200, 32'd1300},
    {16'h0000, 32'd1310},       {16'h0040, 32'd1400},
    {16'h0001, 32'd1500},       {16'h0041, 32'd1600},
    {16'hFFFF, 32'hFFFF_FFF0},  {16'h0000, 32'h0000_0010},
    {16'h8000, 32'hAAAA_AAAA},  {16'h5555, 32'h5555_5555},
    {16'hAAAA, 32'hFFFF_FFFF},  {16'hFFFF, 32'h0000_0000}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [LinesW-1:0]   key_lines;
  logic [TimeW-1:0]    time_ms;
  logic                out_valid;
  logic                out_ready;
  logic [CodeW-1:0]    new_key;
  logic [1:0]          key_state;
  logic [CodeW-1:0]    held_key;

  keypad_tracker       tracker;
  logic                quiet;
  logic [TimeW-1:0]    clock_ms;

  matrix_keypad_scanner DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .key_lines_i (key_lines),
    .time_ms_i   (time_ms),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .new_key_o   (new_key),
    .key_state_o (key_state),
    .held_key_o  (held_key)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #30_000_000;
    $display("matrix_keypad_scanner regression: fail");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CfgDataW-1:0] random_keymap();
    logic [CfgDataW-1:0] map;
    map = {$urandom, $urandom};
    for (int b = 0; b < 8; b++) begin
      if ($urandom_range(0, 3) == 0) map[b*8 +: 8] = '0;
    end
    return map;
  endfunction

  // Tasks below enter and leave at a falling edge.
  task automatic send_poll(logic [LinesW-1:0] lines, logic [TimeW-1:0] now);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    key_lines = lines;
    time_ms   = now;
    do @(posedge clk); while (!in_ready);
    tracker.note_poll(lines, now);
    @(negedge clk);
  endtask

  // Hold polls until every result is back, then let the block settle.
  task automatic drain();
    in_valid = 1'b0;
    while (tracker.pending_reports.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_register(idx, value);
  endtask

  // Narrow registers get random upper bits, which must be dropped.
  task automatic configure(int unsigned rows, int unsigned cols, int unsigned debounce,
                           int unsigned hold, logic [CfgDataW-1:0] map_low,
                           logic [CfgDataW-1:0] map_high);
    logic [CfgDataW-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(CfgRowCount, (junk & ~64'h7) | 64'(rows));
    write_reg(CfgColumnCount, (junk & ~64'h7) | 64'(cols));
    write_reg(CfgDebounceMs, (junk & ~64'hFFFF) | 64'(debounce));
    write_reg(CfgHoldMs, (junk & ~64'hFFFF) | 64'(hold));
    write_reg(CfgKeymapLow, map_low);
    write_reg(CfgKeymapHigh, map_high);
  endtask

  // Mostly press/hold/release episodes on one key, some chords and bounce,
  // the rest random lines at random times.
  task automatic run_phase(int unsigned polls);
    int unsigned       sent;
    int unsigned       step_max;
    int unsigned       press_len;
    int unsigned       rel_len;
    int unsigned       row_max;
    int unsigned       col_max;
    logic [LinesW-1:0] held_lines;
    logic [LinesW-1:0] lines;
    sent = 0;
    while (sent < polls) begin
      step_max = (tracker.debounce_ms + tracker.hold_ms) / 4 + 8;
      if ($urandom_range(0, 4) == 0) step_max *= 4;
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 2) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, step_max);
        send_poll(LinesW'($urandom), clock_ms);
        sent++;
      end else begin
        row_max = (tracker.row_count inside {[1:4]}) ? tracker.row_count - 1 : 3;
        col_max = (tracker.column_count inside {[1:4]}) ? tracker.column_count - 1 : 3;
        if ($urandom_range(0, 5) == 0) begin
          row_max = 3;
          col_max = 3;
        end
        held_lines = 16'h1 << ($urandom_range(0, row_max) * 4 + $urandom_range(0, col_max));
        if ($urandom_range(0, 5) == 0) held_lines |= 16'h1 << $urandom_range(0, 15);
        press_len = $urandom_range(1, 14);
        rel_len   = $urandom_range(1, 5);
        for (int i = 0; i < press_len + rel_len; i++) begin
          lines = (i < press_len) ? held_lines : '0;
          if ($urandom_range(0, 7) == 0) lines ^= held_lines;
          clock_ms += $urandom_range(0, step_max);
          send_poll(lines, clock_ms);
          sent++;
        end
      end
      if ($urandom_range(0, 60) == 0) drain();
    end
  endtask

  // Result side: random ready stalls, checked at the rising edge.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    stall     = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall != 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_report(new_key, key_state, held_key);
    end
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CfgRowCount;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    key_lines = '0;
    time_ms   = '0;
    quiet     = 1'b0;
    clock_ms  = '0;
    tracker   = new();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset values: all codes zero, so every position matches no key
    send_poll(16'hFFFF, 32'd0);
    send_poll(16'h0000, 32'hFFFF_FFFF);
    drain();
    configure(4, 4, 50, 1000, 64'h0800_0605_0403_0201, 64'h100F_0E0D_0C0B_0A09);
    foreach (DirectedPolls[i]) send_poll(DirectedPolls[i][47:32], DirectedPolls[i][31:0]);

    clock_ms = 32'd2000;
    for (int p = 0; p < 10; p++) begin
      drain();
      quiet = (p == 4);
      case (p)
        1: configure(4, 4, 0, 0, random_keymap(), random_keymap());
        2: begin
          configure(7, 7, 65535, 65535, random_keymap(), random_keymap());
          clock_ms = 32'hFFFF_0000;
        end
        3: configure(1, 4, 20, 300, random_keymap(), random_keymap());
        4: configure(4, 1, 5, 100, random_keymap(), random_keymap());
        5: configure(2, 3, 30, 200, 64'h5A5A_0000_5A5A_5A11, 64'h5A5A_5A5A_225A_5A5A);
        6: begin
          configure(0, 4, 10, 100, random_keymap(), random_keymap());
          write_reg(CfgReserved0, {$urandom, $urandom});
          write_reg(CfgReserved1, {$urandom, $urandom});
        end
        7: configure(3, 0, 10, 100, random_keymap(), random_keymap());
        8: configure(5, 3, $urandom_range(0, 400), $urandom_range(0, 3000),
                     64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        9: configure($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 300),
                     $urandom_range(0, 2000), random_keymap(), random_keymap());
        default: ;
      endcase
      run_phase((p == 6 || p == 7) ? 30 : 110);
    end
    drain();

    if (tracker.failures == 0) begin
      $display("matrix_keypad_scanner regression: pass");
    end else begin
      $display("matrix_keypad_scanner regression: fail");
    end
    $finish;
  end

endmodule
